@@ rtl/rspe_pkg.sv @@
// Shared constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
package rspe_pkg;

  localparam int MaxParity   = 32;
  localparam int ResetParity = 10;
  localparam int CountW      = 6;
  localparam logic [8:0] GfPoly = 9'h11D;

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly[7:0] : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

  // Zero counts as degree one; counts above the storage depth saturate.
  function automatic int eff_degree(input logic [CountW-1:0] raw, input int max_p);
    if (raw == '0) begin
      return 1;
    end
    if (int'(raw) > max_p) begin
      return max_p;
    end
    return int'(raw);
  endfunction

endpackage

@@ rtl/rspe_in_if.sv @@
// Input channel carrying one message byte per transaction.
interface rspe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

@@ rtl/rspe_out_if.sv @@
// Output channel carrying one parity byte per transaction.
interface rspe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] parity_byte;
  logic       parity_last;

  modport source (output valid, output parity_byte, output parity_last, input ready);
  modport sink (input valid, input parity_byte, input parity_last, output ready);
endinterface

@@ rtl/rspe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rspe_gf_mul.sv @@
// Shared GF(256) multiplier over the field polynomial 0x11D.
module rspe_gf_mul import rspe_pkg::*; (
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] p
);

  assign p = gf_mul(a, b);

endmodule

@@ rtl/reed_solomon_parity_encoder_unit.sv @@
// Top level of the iterative Reed-Solomon parity encoder.
// Systematic RS parity encoder over GF(256), polynomial 0x11D, with d parity bytes per block
// (d set by the parity count register, zero meaning one, saturating at MAX_PARITY). All work
// runs through one GF multiplier and one read port on each of two small RAMs (generator and
// remainder), so the block takes no new data byte until the last one has gone through accept,
// head read, factor, then a pass streaming the remainder update. On a byte marked as block end,
// each parity byte then goes through read, load and a hold that waits on the output ready, head
// first with the last one flagged, and the remainder entry is cleared as it is read out.
// After reset and after every write of the parity count the block is not ready while it
// clears the remainder and derives the generator, one pass per root.
module reed_solomon_parity_encoder_unit import rspe_pkg::*; #(
  parameter int MAX_PARITY = MaxParity
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata,
  rspe_in_if.sink           data_in,
  rspe_out_if.source        parity_out
);

  localparam int AW = $clog2(MAX_PARITY);
  localparam int DW = $clog2(MAX_PARITY + 1);
  localparam int CW = $clog2(MAX_PARITY + 2);

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_DERIVE    = 9'b000000010,
    S_IDLE      = 9'b000000100,
    S_HEAD      = 9'b000001000,
    S_FACTOR    = 9'b000010000,
    S_ENCODE    = 9'b000100000,
    S_EMIT_RD   = 9'b001000000,
    S_EMIT_LD   = 9'b010000000,
    S_EMIT_HOLD = 9'b100000000
  } state_t;

  state_t        state;
  logic [CW-1:0] k;
  logic [DW-1:0] outer;
  logic [DW-1:0] deg;
  logic [7:0]    root;
  logic [7:0]    held;
  logic [7:0]    factor;
  logic [7:0]    data_q;
  logic          end_q;
  logic          out_valid;
  logic [7:0]    out_byte;
  logic          out_last;

  logic [CW-1:0] deg_c;
  logic [CW-1:0] deg_m1;
  logic [CW-1:0] km1;
  logic [CW-1:0] km2;
  logic [CW-1:0] kp1;

  logic          g_we;
  logic [AW-1:0] g_waddr;
  logic [7:0]    g_wdata;
  logic [AW-1:0] g_raddr;
  logic [7:0]    g_rdata;
  logic          r_we;
  logic [AW-1:0] r_waddr;
  logic [7:0]    r_wdata;
  logic [AW-1:0] r_raddr;
  logic [7:0]    r_rdata;
  logic [7:0]    mul_a;
  logic [7:0]    mul_b;
  logic [7:0]    mul_p;

  assign deg_c  = CW'(deg);
  assign deg_m1 = deg_c - CW'(1);
  assign km1    = k - CW'(1);
  assign km2    = k - CW'(2);
  assign kp1    = k + CW'(1);

  assign data_in.ready          = (state == S_IDLE);
  assign parity_out.valid       = out_valid;
  assign parity_out.parity_byte = out_byte;
  assign parity_out.parity_last = out_last;

  rspe_ram #(.WIDTH(8), .DEPTH(MAX_PARITY)) u_gen_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  rspe_ram #(.WIDTH(8), .DEPTH(MAX_PARITY)) u_rem_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  rspe_gf_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // Both passes stream one entry per cycle: the read issued at one step returns at the next,
  // and the entry it completes is written one or two entries behind the read pointer.
  always_comb begin
    g_we    = 1'b0;
    g_waddr = k[AW-1:0];
    g_wdata = 8'h00;
    g_raddr = k[AW-1:0];
    r_we    = 1'b0;
    r_waddr = k[AW-1:0];
    r_wdata = 8'h00;
    r_raddr = k[AW-1:0];
    mul_a   = g_rdata;
    mul_b   = factor;
    unique case (state)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_wdata = (k == deg_m1) ? 8'h01 : 8'h00;
        r_we    = 1'b1;
      end
      S_DERIVE: begin
        mul_a   = held;
        mul_b   = root;
        g_we    = (k >= CW'(2));
        g_waddr = km2[AW-1:0];
        g_wdata = mul_p ^ ((k <= deg_c) ? g_rdata : 8'h00);
      end
      S_HEAD: begin
        r_raddr = '0;
      end
      S_ENCODE: begin
        r_raddr = kp1[AW-1:0];
        r_we    = (k != '0);
        r_waddr = km1[AW-1:0];
        r_wdata = ((k < deg_c) ? r_rdata : 8'h00) ^ mul_p;
      end
      S_EMIT_LD: begin
        r_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      k         <= '0;
      outer     <= '0;
      deg       <= DW'(eff_degree(CountW'(ResetParity), MAX_PARITY));
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      state     <= S_CLEAR;
      k         <= '0;
      outer     <= '0;
      deg       <= DW'(eff_degree(cfg_wdata, MAX_PARITY));
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (k == deg_m1) begin
            state <= S_DERIVE;
            k     <= '0;
            outer <= '0;
          end else begin
            k <= kp1;
          end
        end
        S_DERIVE: begin
          if (k == deg_c + CW'(1)) begin
            k <= '0;
            if (outer == deg - DW'(1)) begin
              state <= S_IDLE;
            end else begin
              outer <= outer + DW'(1);
            end
          end else begin
            k <= kp1;
          end
        end
        S_IDLE: begin
          if (data_in.valid) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_FACTOR;
        end
        S_FACTOR: begin
          state <= S_ENCODE;
          k     <= '0;
        end
        S_ENCODE: begin
          if (k == deg_c) begin
            k     <= '0;
            state <= end_q ? S_EMIT_RD : S_IDLE;
          end else begin
            k <= kp1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (parity_out.ready) begin
            out_valid <= 1'b0;
            if (k == deg_m1) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k     <= kp1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
          k     <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    held <= g_rdata;
    if (state == S_CLEAR) begin
      root <= 8'h01;
    end else if (state == S_DERIVE && k == deg_c + CW'(1)) begin
      root <= gf_xtime(root);
    end
    if (data_in.valid && data_in.ready) begin
      data_q <= data_in.data_byte;
      end_q  <= data_in.block_end;
    end
    if (state == S_FACTOR) begin
      factor <= data_q ^ r_rdata;
    end
    if (state == S_EMIT_LD) begin
      out_byte <= r_rdata;
      out_last <= (k == deg_m1);
    end
  end

  // A parity byte is only offered while the sequencer waits for it to be taken.
  a_valid_in_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_EMIT_HOLD)
    else $error("parity output valid outside the emit hold state");

  // The encoder never takes a new byte while a parity transaction is pending.
  a_no_accept_during_emit: assert property (@(posedge clk) disable iff (rst)
    data_in.ready |-> !out_valid)
    else $error("input ready while parity output is pending");

  // The remainder is never modified while the block is waiting for input.
  a_idle_no_rem_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !r_we)
    else $error("remainder written while idle");

  // The working degree stays within the storage depth.
  a_degree_range: assert property (@(posedge clk) disable iff (rst)
    deg != '0 && deg <= DW'(MAX_PARITY))
    else $error("degree out of range");

  // The last flag goes out only on the final remainder entry.
  a_last_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> k == deg_m1)
    else $error("last flag on a non-final parity byte");

endmodule
